// ===== rtl/min_distance_sample_filter_defines.svh =====
// Assertion macros for the minimum-distance sample filter.
// Included by the top level; no other dependencies.
`ifndef MIN_DISTANCE_SAMPLE_FILTER_DEFINES_SVH
`define MIN_DISTANCE_SAMPLE_FILTER_DEFINES_SVH

`ifndef ASSERT_OFF
`define MDSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define MDSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MDSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MDSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/mdsf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes of the minimum-distance sample filter.
// No dependencies; imported by every module of the block.
package mdsf_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int PTR_W       = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = 7;
  localparam int COORD_W     = 16;
  localparam int IDX_W       = 16;
  localparam int PC_W        = 16;
  localparam int TGT_W       = 7;
  localparam int THR_W       = 34;
  localparam int MAXREJ_W    = 16;
  localparam int REJ_W       = 17;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int SQ_W        = 2 * DIFF_W;
  localparam int DIST_LAT    = 3;
  localparam int DRAIN_W     = $clog2(DIST_LAT);
  localparam int STAT_W      = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 34;

  localparam logic [STAT_W-1:0] ST_ACCEPT = 3'd0;
  localparam logic [STAT_W-1:0] ST_CLOSE  = 3'd1;
  localparam logic [STAT_W-1:0] ST_DONE   = 3'd2;
  localparam logic [STAT_W-1:0] ST_GAVEUP = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REJ     = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } dist_res_t;

endpackage

// ===== rtl/mdsf_cell.sv =====
`timescale 1ns / 1ps
// One cell of the stored-sample ring: holds one accepted point.
// Depends on mdsf_pkg.
module mdsf_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  logic            load_en,
  input  mdsf_pkg::point_t shift_in,
  input  mdsf_pkg::point_t load_pt,
  output mdsf_pkg::point_t pt_out
);
  import mdsf_pkg::*;

  point_t pt_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      pt_r <= load_pt;
    end else if (shift_en) begin
      pt_r <= shift_in;
    end
  end

  assign pt_out = pt_r;

endmodule

// ===== rtl/mdsf_dist.sv =====
`timescale 1ns / 1ps
// Pipelined squared-distance compare: difference, square, sum and compare.
// Depends on mdsf_pkg.
module mdsf_dist (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  mdsf_pkg::point_t            pa,
  input  mdsf_pkg::point_t            pb,
  input  logic [mdsf_pkg::THR_W-1:0]  thr,
  output mdsf_pkg::dist_res_t         res
);
  import mdsf_pkg::*;

  logic                     v1_r, v2_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic signed [SQ_W-1:0]   px, py, pz;
  logic [SQ_W-1:0]          sqx_r, sqy_r, sqz_r;
  logic [SQ_W-1:0]          sum;
  dist_res_t                res_r;

  assign px  = dx_r * dx_r;
  assign py  = dy_r * dy_r;
  assign pz  = dz_r * dz_r;
  assign sum = sqx_r + sqy_r + sqz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      res_r <= '0;
    end else begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      res_r.valid <= v2_r;
      res_r.hit   <= v2_r && (sum < thr);
    end
  end

  always_ff @(posedge clk) begin
    dx_r  <= DIFF_W'(pa.x) - DIFF_W'(pb.x);
    dy_r  <= DIFF_W'(pa.y) - DIFF_W'(pb.y);
    dz_r  <= DIFF_W'(pa.z) - DIFF_W'(pb.z);
    sqx_r <= px;
    sqy_r <= py;
    sqz_r <= pz;
  end

  assign res = res_r;

endmodule

// ===== rtl/min_distance_sample_filter.sv =====
`timescale 1ns / 1ps
// Minimum-distance sample filter: one candidate point in, one status result out.
// The in_ channel carries a candidate (index, x, y, z) with start_new on in_tuser.
// The out_ channel returns status on out_tuser, index and accepted count on
// out_tdata, and finished on out_tlast. Exactly one result per transaction.
// Accepted points sit in a ring of 64 cells. A candidate that needs a distance
// check rotates the ring once past a three-stage squared-distance unit, so its
// result is written once the ring has turned and the distance pipeline has
// drained; the ring length sets this wait, and the next candidate is taken only
// once that result is in the output register.
// Candidates answered without a check (bad setup, run already over, target
// already met) give their result in the cycle after acceptance.
// A new transaction is taken once the result register is free or being
// emptied, so a result may leave in the cycle the next candidate enters.
// When the receiver stalls, the result holds and further input stalls.
// Reset (rst_n low, synchronous) clears counters, the run flag and the
// registers to their defaults; stored points need no clearing.
// Write cfg_we/cfg_index/cfg_data configuration only while idle; not enforced.
`include "min_distance_sample_filter_defines.svh"
module min_distance_sample_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // cand_index [15:0], cand_x [31:16], cand_y [47:32], cand_z [63:48]
  input  logic [63:0]                       in_tdata,
  // start_new [0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_index [15:0], accepted_count [22:16], zero [23]
  output logic [23:0]                       out_tdata,
  // status [2:0]
  output logic [mdsf_pkg::STAT_W-1:0]       out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [mdsf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mdsf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mdsf_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_DRAIN, S_RESULT} state_t;

  localparam logic [PTR_W-1:0] K_LAST = PTR_W'(MAX_SAMPLES - 1);
  localparam logic [DRAIN_W-1:0] D_LAST = DRAIN_W'(DIST_LAT - 1);

  logic [PC_W-1:0]     pc_r;
  logic [TGT_W-1:0]    tgt_r;
  logic [THR_W-1:0]    thr_r;
  logic [MAXREJ_W-1:0] maxrej_r;

  state_t              st_r, st_nxt;
  logic [PTR_W-1:0]    k_r, k_nxt;
  logic [DRAIN_W-1:0]  drain_r, drain_nxt;
  logic                close_r, close_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [REJ_W-1:0]    rej_r, rej_nxt;
  logic                stop_r, stop_nxt;
  logic                ov_r, ov_nxt;
  logic [STAT_W-1:0]   ostat_r, ostat_nxt;
  logic [IDX_W-1:0]    oidx_r, oidx_nxt;
  logic [CNT_W-1:0]    ocnt_r, ocnt_nxt;
  logic                ofin_r, ofin_nxt;
  point_t              cand_r, cand_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;

  logic                out_free, in_fire, bad_setup, feed_valid, load_go;
  logic [CNT_W-1:0]    cnt_eff, cnt_inc;
  logic                stop_eff;
  logic [REJ_W-1:0]    rej_inc;
  point_t              in_pt;
  point_t              ring_pt [MAX_SAMPLES];
  dist_res_t           dres;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= PC_W'(65535);
      tgt_r    <= TGT_W'(16);
      thr_r    <= '0;
      maxrej_r <= MAXREJ_W'(1000);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POINT_COUNT: pc_r     <= cfg_data[PC_W-1:0];
        REG_TARGET:      tgt_r    <= cfg_data[TGT_W-1:0];
        REG_THRESHOLD:   thr_r    <= cfg_data[THR_W-1:0];
        REG_MAX_REJ:     maxrej_r <= cfg_data[MAXREJ_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_pt.x  = in_tdata[31:16];
  assign in_pt.y  = in_tdata[47:32];
  assign in_pt.z  = in_tdata[63:48];

  assign out_free  = !ov_r || out_tready;
  assign in_tready = (st_r == S_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;

  assign bad_setup = (tgt_r == '0) || ({{(PC_W-TGT_W){1'b0}}, tgt_r} > pc_r) ||
                     (tgt_r > TGT_W'(MAX_SAMPLES));
  assign cnt_eff   = in_tuser ? '0 : cnt_r;
  assign stop_eff  = in_tuser ? 1'b0 : stop_r;
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign rej_inc   = (rej_r == '1) ? rej_r : rej_r + REJ_W'(1);

  assign feed_valid = (st_r == S_SWEEP) && (CNT_W'(k_r) < cnt_r);
  assign load_go    = (st_r == S_RESULT) && out_free && !close_r;

  // ring of stored points; cell 0 feeds the distance unit
  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_ring
    mdsf_cell u_cell (
      .clk      (clk),
      .shift_en (st_r == S_SWEEP),
      .load_en  (load_go && (cnt_r == CNT_W'(i))),
      .shift_in (ring_pt[(i + 1) % MAX_SAMPLES]),
      .load_pt  (cand_r),
      .pt_out   (ring_pt[i])
    );
  end

  mdsf_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (feed_valid),
    .pa       (ring_pt[0]),
    .pb       (cand_r),
    .thr      (thr_r),
    .res      (dres)
  );

  always_comb begin
    st_nxt    = st_r;
    k_nxt     = k_r;
    drain_nxt = drain_r;
    close_nxt = close_r | (dres.valid & dres.hit);
    cnt_nxt   = cnt_r;
    rej_nxt   = rej_r;
    stop_nxt  = stop_r;
    ov_nxt    = ov_r && !out_tready;
    ostat_nxt = ostat_r;
    oidx_nxt  = oidx_r;
    ocnt_nxt  = ocnt_r;
    ofin_nxt  = ofin_r;
    cand_nxt  = cand_r;
    idx_nxt   = idx_r;
    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          cand_nxt  = in_pt;
          idx_nxt   = in_tdata[15:0];
          close_nxt = 1'b0;
          if (in_tuser) begin
            cnt_nxt  = '0;
            rej_nxt  = '0;
            stop_nxt = 1'b0;
          end
          oidx_nxt = '0;
          ocnt_nxt = cnt_eff;
          ofin_nxt = 1'b1;
          if (bad_setup) begin
            ov_nxt    = 1'b1;
            ostat_nxt = ST_BAD;
          end else if (stop_eff) begin
            ov_nxt    = 1'b1;
            ostat_nxt = ({1'b0, cnt_eff} >= {1'b0, tgt_r}) ? ST_DONE : ST_GAVEUP;
          end else if (cnt_eff >= tgt_r) begin
            ov_nxt    = 1'b1;
            stop_nxt  = 1'b1;
            ostat_nxt = ST_DONE;
          end else begin
            st_nxt = S_SWEEP;
            k_nxt  = '0;
          end
        end
      end
      S_SWEEP: begin
        k_nxt = k_r + PTR_W'(1);
        if (k_r == K_LAST) begin
          st_nxt    = S_DRAIN;
          drain_nxt = '0;
        end
      end
      S_DRAIN: begin
        drain_nxt = drain_r + DRAIN_W'(1);
        if (drain_r == D_LAST) begin
          st_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
          if (!close_r) begin
            cnt_nxt   = cnt_inc;
            rej_nxt   = '0;
            stop_nxt  = (cnt_inc >= tgt_r);
            ostat_nxt = ST_ACCEPT;
            oidx_nxt  = idx_r;
            ocnt_nxt  = cnt_inc;
            ofin_nxt  = (cnt_inc >= tgt_r);
          end else begin
            rej_nxt   = rej_inc;
            stop_nxt  = (rej_inc > {1'b0, maxrej_r});
            ostat_nxt = ST_CLOSE;
            oidx_nxt  = '0;
            ocnt_nxt  = cnt_r;
            ofin_nxt  = (rej_inc > {1'b0, maxrej_r});
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      k_r     <= '0;
      drain_r <= '0;
      close_r <= 1'b0;
      cnt_r   <= '0;
      rej_r   <= '0;
      stop_r  <= 1'b0;
      ov_r    <= 1'b0;
      ostat_r <= ST_ACCEPT;
      oidx_r  <= '0;
      ocnt_r  <= '0;
      ofin_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      k_r     <= k_nxt;
      drain_r <= drain_nxt;
      close_r <= close_nxt;
      cnt_r   <= cnt_nxt;
      rej_r   <= rej_nxt;
      stop_r  <= stop_nxt;
      ov_r    <= ov_nxt;
      ostat_r <= ostat_nxt;
      oidx_r  <= oidx_nxt;
      ocnt_r  <= ocnt_nxt;
      ofin_r  <= ofin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
    idx_r  <= idx_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = ostat_r;
  assign out_tdata  = {1'b0, ocnt_r, oidx_r};
  assign out_tlast  = ofin_r;

  `MDSF_ASSERT_IMP(a_accept_counts, clk, rst_n, ov_r && (ostat_r == ST_ACCEPT), ocnt_r != '0)
  `MDSF_ASSERT_IMP(a_bad_finishes, clk, rst_n, ov_r && (ostat_r == ST_BAD), ofin_r && (oidx_r == '0))
  `MDSF_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(MAX_SAMPLES))
  `MDSF_ASSERT_NXT(a_sweep_ends, clk, rst_n, (st_r == S_SWEEP) && (k_r == K_LAST), st_r == S_DRAIN)

endmodule
